>>> sv/trpd_pkg.sv
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types, register indexes and the 5-bit to 8-bit colour table for the
// TGA RLE pixel decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_PIXEL_BYTES = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_RLE_ENABLED = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ROW_WIDTH   = 2'd2;

	localparam logic [2:0]  PIXEL_BYTES_RST = 3'd4;
	localparam logic        RLE_ENABLED_RST = 1'b1;
	localparam logic [15:0] ROW_WIDTH_RST   = 16'd640;

	localparam logic [7:0] RUN_FLAG_MASK = 8'h80;
	localparam logic [7:0] RUN_LEN_MASK  = 8'h7F;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

	// floor(v * 255 / 31)
	localparam logic [7:0] SCALE5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_res;
		logic       row_end;
	} res_t;

	function automatic logic [7:0] scale5(input logic [4:0] v);
		return SCALE5[v];
	endfunction

endpackage

>>> sv/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Turns a stream of TGA pixel-data bytes into colour results with repeat
// counts and row-end marks, with or without RLE packet coding.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   data_byte
//   out      source     out_valid/out_stall red green blue alpha repeat_res row_end
//   cfg      sink       cfg_wen             cfg_index cfg_data
//
// One byte a cycle while in_stall is low. A byte sits in the input register; its
// result, if any, goes to the output register, or to the skid buffer while that
// register is stalled. The output register has a one-entry skid buffer; in_stall
// rises only while the skid buffer is full, and is driven from registers alone.
// Reset restores the register defaults and waits for a packet header.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [trpd_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [trpd_pkg::CfgDataW-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic [7:0]                      alpha,
	output logic [7:0]                      repeat_res,
	output logic                            row_end
);
	import trpd_pkg::*;

	logic [2:0]  pixel_bytes_q;
	logic        rle_enabled_q;
	logic [15:0] row_width_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        expect_header_q;
	logic [7:0]  packet_left_q;
	logic        run_packet_q;
	logic [7:0]  packet_length_q;
	logic [1:0]  byte_position_q;
	logic [23:0] pixel_gather_q;
	logic [16:0] row_count_q;

	res_t        res_s2;
	logic        valid_s2;
	res_t        skid_q;
	logic        skid_valid_q;

	logic        fire;
	logic        take;
	logic [1:0]  pb_m1;
	logic        complete;
	logic [23:0] gather_ins;
	logic [15:0] pix_word;
	logic [16:0] row_inc;
	logic [16:0] width_ext;
	logic [7:0]  hdr_len;
	logic [7:0]  left_after;
	logic        res_ok;
	res_t        res_new;

	logic        n_expect_header;
	logic [7:0]  n_packet_left;
	logic        n_run_packet;
	logic [7:0]  n_packet_length;
	logic [1:0]  n_byte_position;
	logic [23:0] n_pixel_gather;
	logic [16:0] n_row_count;

	assign in_stall = valid_s1 & skid_valid_q;
	assign fire     = valid_s1 & ~skid_valid_q;
	assign take     = valid_s2 & ~out_stall;

	assign out_valid  = valid_s2;
	assign red        = res_s2.red;
	assign green      = res_s2.green;
	assign blue       = res_s2.blue;
	assign alpha      = res_s2.alpha;
	assign repeat_res = res_s2.repeat_res;
	assign row_end    = res_s2.row_end;

	always_comb begin
		case (pixel_bytes_q)
			3'd0, 3'd1: pb_m1 = 2'd0;
			3'd2:       pb_m1 = 2'd1;
			3'd3:       pb_m1 = 2'd2;
			default:    pb_m1 = 2'd3;
		endcase
	end

	assign complete  = byte_position_q >= pb_m1;
	assign pix_word  = {byte_s1, pixel_gather_q[7:0]};
	assign width_ext = {1'b0, row_width_q};
	assign row_inc   = row_count_q + 17'd1;
	assign hdr_len   = (byte_s1 & RUN_LEN_MASK) + 8'd1;
	assign left_after = run_packet_q ? 8'd0 :
		((packet_left_q != 8'd0) ? packet_left_q - 8'd1 : 8'd0);

	always_comb begin
		case (byte_position_q)
			2'd0:    gather_ins = pixel_gather_q | {16'd0, byte_s1};
			2'd1:    gather_ins = pixel_gather_q | {8'd0, byte_s1, 8'd0};
			2'd2:    gather_ins = pixel_gather_q | {byte_s1, 16'd0};
			default: gather_ins = pixel_gather_q;
		endcase
	end

	// colour of the completing pixel, and next decoder state
	always_comb begin
		res_new.alpha = ALPHA_OPAQUE;
		case (pb_m1)
			2'd0: begin
				res_new.red   = byte_s1;
				res_new.green = byte_s1;
				res_new.blue  = byte_s1;
			end
			2'd1: begin
				res_new.red   = scale5(pix_word[14:10]);
				res_new.green = scale5(pix_word[9:5]);
				res_new.blue  = scale5(pix_word[4:0]);
			end
			2'd2: begin
				res_new.blue  = pixel_gather_q[7:0];
				res_new.green = pixel_gather_q[15:8];
				res_new.red   = byte_s1;
			end
			default: begin
				res_new.blue  = pixel_gather_q[7:0];
				res_new.green = pixel_gather_q[15:8];
				res_new.red   = pixel_gather_q[23:16];
				res_new.alpha = byte_s1;
			end
		endcase
		res_new.repeat_res = 8'd1;
		res_new.row_end    = 1'b0;

		res_ok          = 1'b0;
		n_expect_header = expect_header_q;
		n_packet_left   = packet_left_q;
		n_run_packet    = run_packet_q;
		n_packet_length = packet_length_q;
		n_byte_position = byte_position_q;
		n_pixel_gather  = pixel_gather_q;
		n_row_count     = row_count_q;

		if (!rle_enabled_q) begin
			if (complete) begin
				res_ok          = 1'b1;
				n_byte_position = 2'd0;
				n_pixel_gather  = 24'd0;
				if (row_inc >= width_ext) begin
					res_new.row_end = 1'b1;
					n_row_count     = 17'd0;
				end else begin
					n_row_count = row_inc;
				end
			end else begin
				n_byte_position = byte_position_q + 2'd1;
				n_pixel_gather  = gather_ins;
			end
		end else if (expect_header_q) begin
			n_run_packet    = (byte_s1 & RUN_FLAG_MASK) != 8'd0;
			n_packet_length = hdr_len;
			n_packet_left   = hdr_len;
			n_expect_header = 1'b0;
			n_byte_position = 2'd0;
			n_pixel_gather  = 24'd0;
			n_row_count     = row_count_q + {9'd0, hdr_len};
		end else if (!complete) begin
			n_byte_position = byte_position_q + 2'd1;
			n_pixel_gather  = gather_ins;
		end else begin
			res_ok          = 1'b1;
			n_byte_position = 2'd0;
			n_pixel_gather  = 24'd0;
			n_packet_left   = left_after;
			if (run_packet_q) begin
				res_new.repeat_res = packet_length_q;
			end
			if (left_after == 8'd0) begin
				n_expect_header = 1'b1;
				if (row_count_q >= width_ext) begin
					res_new.row_end = 1'b1;
					n_row_count     = 17'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PIXEL_BYTES_RST;
			rle_enabled_q <= RLE_ENABLED_RST;
			row_width_q   <= ROW_WIDTH_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[2:0];
				CFG_RLE_ENABLED: rle_enabled_q <= cfg_data[0];
				CFG_ROW_WIDTH:   row_width_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			packet_left_q   <= 8'd0;
			run_packet_q    <= 1'b0;
			packet_length_q <= 8'd0;
			byte_position_q <= 2'd0;
			pixel_gather_q  <= 24'd0;
			row_count_q     <= 17'd0;
		end else if (fire) begin
			expect_header_q <= n_expect_header;
			packet_left_q   <= n_packet_left;
			run_packet_q    <= n_run_packet;
			packet_length_q <= n_packet_length;
			byte_position_q <= n_byte_position;
			pixel_gather_q  <= n_pixel_gather;
			row_count_q     <= n_row_count;
		end
	end

	// output register with skid buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!valid_s2 || take) begin
			valid_s2     <= skid_valid_q | (fire & res_ok);
			skid_valid_q <= 1'b0;
		end else if (fire && res_ok) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s2 || take) begin
			if (skid_valid_q) begin
				res_s2 <= skid_q;
			end else if (fire && res_ok) begin
				res_s2 <= res_new;
			end
		end else if (fire && res_ok) begin
			skid_q <= res_new;
		end
	end

endmodule
